// File: hw/rtl/trc_pkg.sv
package trc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;
  localparam int NUM_EDGES  = 3;
  localparam int NUM_COORDS = 8;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int SUM_W  = EDGE_W + 2;

  localparam int IN_DATA_W  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  typedef enum logic {
    CFG_CULL_ENABLE = 1'b0,
    CFG_CCW_FRONT   = 1'b1
  } cfg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_val_t;

  typedef struct packed {
    logic tl_fwd;
    logic tl_rev;
  } edge_flags_t;

endpackage

// File: hw/rtl/triangle_pixel_coverage_test_top.sv
// Triangle sample coverage test. Each input beat carries three vertices and a
// sample point in signed 12.4 fixed point (y grows downward); each output beat
// carries one coverage bit. Edge functions are exact, samples on an edge count
// only for top or left edges, zero-area triangles never cover. One beat enters
// every clock unless out stalls; the pipeline registers differences, products,
// edge sums and the decision. Back-pressure on out stalls the whole pipeline.
// Configure cull_enable (index 0) and ccw_front (index 1) only while idle.
module triangle_pixel_coverage_test_top
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
  // vertex_c_x, vertex_c_y, sample_x, sample_y (16 bits each)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // covered, then zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic                  cfg_wdata
);

  coord_t      crd [NUM_COORDS];
  edge_val_t   e_val   [NUM_EDGES];
  edge_flags_t e_flags [NUM_EDGES];
  logic        adv, covered;
  logic        cull_r, ccw_r;
  logic        v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    for (int i = 0; i < NUM_COORDS; i++) begin
      crd[i] = coord_t'(in_tdata[i*COORD_BITS +: COORD_BITS]);
    end
  end

  assign adv       = !v4_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cull_r <= 1'b0;
      ccw_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CULL_ENABLE: cull_r <= cfg_wdata;
        CFG_CCW_FRONT:   ccw_r  <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // AB, BC, CA
  trc_edge u_edge_ab (
    .clk(clk), .adv(adv),
    .ux(crd[0]), .uy(crd[1]), .vx(crd[2]), .vy(crd[3]), .px(crd[6]), .py(crd[7]),
    .e_val(e_val[0]), .e_flags(e_flags[0])
  );

  trc_edge u_edge_bc (
    .clk(clk), .adv(adv),
    .ux(crd[2]), .uy(crd[3]), .vx(crd[4]), .vy(crd[5]), .px(crd[6]), .py(crd[7]),
    .e_val(e_val[1]), .e_flags(e_flags[1])
  );

  trc_edge u_edge_ca (
    .clk(clk), .adv(adv),
    .ux(crd[4]), .uy(crd[5]), .vx(crd[0]), .vy(crd[1]), .px(crd[6]), .py(crd[7]),
    .e_val(e_val[2]), .e_flags(e_flags[2])
  );

  trc_decide u_decide (
    .clk(clk), .adv(adv),
    .cull_enable(cull_r), .ccw_front(ccw_r),
    .e_val(e_val), .e_flags(e_flags),
    .covered(covered)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, covered};

endmodule

// File: hw/rtl/trc_edge.sv
module trc_edge
  import trc_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  coord_t      ux,
  input  coord_t      uy,
  input  coord_t      vx,
  input  coord_t      vy,
  input  coord_t      px,
  input  coord_t      py,
  output edge_val_t   e_val,
  output edge_flags_t e_flags
);

  logic signed [DIFF_W-1:0] dx_r, dy_r, dpx_r, dpy_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dpx_nxt, dpy_nxt;
  logic signed [PROD_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  edge_flags_t              fl2_r, fl2_nxt, fl3_r;
  edge_val_t                e_r, e_nxt;

  // stage 1: differences
  assign dx_nxt  = DIFF_W'(vx) - DIFF_W'(ux);
  assign dy_nxt  = DIFF_W'(vy) - DIFF_W'(uy);
  assign dpx_nxt = DIFF_W'(px) - DIFF_W'(ux);
  assign dpy_nxt = DIFF_W'(py) - DIFF_W'(uy);

  // stage 2: products and fill-rule flags
  assign p1_nxt = PROD_W'(dpy_r) * PROD_W'(dx_r);
  assign p2_nxt = PROD_W'(dpx_r) * PROD_W'(dy_r);
  assign fl2_nxt.tl_fwd = (dy_r > 0) || (dy_r == 0 && dx_r < 0);
  assign fl2_nxt.tl_rev = (dy_r < 0) || (dy_r == 0 && dx_r > 0);

  // stage 3: edge function
  assign e_nxt = EDGE_W'(p1_r) - EDGE_W'(p2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dpx_r <= dpx_nxt;
      dpy_r <= dpy_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      fl2_r <= fl2_nxt;
      e_r   <= e_nxt;
      fl3_r <= fl2_r;
    end
  end

  assign e_val   = e_r;
  assign e_flags = fl3_r;

endmodule

// File: hw/rtl/trc_decide.sv
module trc_decide
  import trc_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic        cull_enable,
  input  logic        ccw_front,
  input  edge_val_t   e_val   [NUM_EDGES],
  input  edge_flags_t e_flags [NUM_EDGES],
  output logic        covered
);

  logic [NUM_EDGES-1:0]    inc_f, inc_b;
  logic                    front, back, hit;
  logic signed [SUM_W-1:0] total;
  logic                    covered_r, covered_nxt;

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      inc_f[i] = (e_val[i] > 0) || (e_val[i] == 0 && e_flags[i].tl_fwd);
      inc_b[i] = (e_val[i] < 0) || (e_val[i] == 0 && e_flags[i].tl_rev);
    end
  end

  assign total  = SUM_W'(e_val[0]) + SUM_W'(e_val[1]) + SUM_W'(e_val[2]);
  assign front  = ccw_front ? (&inc_b) : (&inc_f);
  assign back   = ccw_front ? (&inc_f) : (&inc_b);
  assign hit    = cull_enable ? front : (front || back);
  assign covered_nxt = hit && (total != 0);

  always_ff @(posedge clk) begin
    if (adv) begin
      covered_r <= covered_nxt;
    end
  end

  assign covered = covered_r;

endmodule

// File: hw/rtl/trc_checker.sv
module trc_checker
  import trc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat dropped or changed under stall");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:1] == 0)
    else $error("out fill bits not zero");

  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

  a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready)
    ##1 (!out_tvalid || out_tready) && !(in_tvalid && in_tready)
    ##1 (!out_tvalid || out_tready) && !(in_tvalid && in_tready)
    ##1 (!out_tvalid || out_tready) && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("out beat without an input beat");

endmodule

bind triangle_pixel_coverage_test_top trc_checker u_trc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: verif/triangle_pixel_coverage_test_top_test.sv
`timescale 1ns / 1ps

module triangle_pixel_coverage_test_top_test;
  import trc_pkg::*;

  localparam int SEGMENTS      = 6;
  localparam int RANDOM_PER_SEG = 255;
  localparam int DRAIN_CYCLES  = 8;
  localparam longint CYCLE_LIMIT = 200000;

  // lowest member (ax) sits in the lowest tdata bits
  typedef struct packed {
    coord_t py;
    coord_t px;
    coord_t cy;
    coord_t cx;
    coord_t by;
    coord_t bx;
    coord_t ay;
    coord_t ax;
  } tri_beat_t;

  class coverage_scoreboard;
    bit cull_en;
    bit ccw_fr;
    bit covered_q[$];
    int errors;

    function void set_mode(bit cull, bit ccw);
      cull_en = cull;
      ccw_fr  = ccw;
    endfunction

    function int pending();
      return covered_q.size();
    endfunction

    function bit edge_holds(longint e, longint ux, longint uy, longint vx, longint vy);
      longint dx;
      longint dy;
      dx = vx - ux;
      dy = vy - uy;
      return e > 0 || (e == 0 && (dy > 0 || (dy == 0 && dx < 0)));
    endfunction

    function bit predict_covered(tri_beat_t t);
      longint ax, ay, bx, by, cx, cy, px, py;
      longint e_ab, e_bc, e_ca;
      bit front, back, tmp, hit;
      ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
      cx = t.cx; cy = t.cy; px = t.px; py = t.py;
      e_ab = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
      e_bc = (py - by) * (cx - bx) - (px - bx) * (cy - by);
      e_ca = (py - cy) * (ax - cx) - (px - cx) * (ay - cy);
      front = edge_holds(e_ab, ax, ay, bx, by) && edge_holds(e_bc, bx, by, cx, cy) &&
              edge_holds(e_ca, cx, cy, ax, ay);
      back  = edge_holds(-e_ab, bx, by, ax, ay) && edge_holds(-e_bc, cx, cy, bx, by) &&
              edge_holds(-e_ca, ax, ay, cx, cy);
      if (ccw_fr) begin
        tmp   = front;
        front = back;
        back  = tmp;
      end
      hit = cull_en ? front : (front || back);
      return hit && (e_ab + e_bc + e_ca != 0);
    endfunction

    function void note_input(tri_beat_t t);
      covered_q.push_back(predict_covered(t));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      bit want;
      if (covered_q.size() == 0) begin
        $error("covered: no beat expected, got %0b", d[0]);
        errors++;
        return;
      end
      want = covered_q.pop_front();
      if (d[0] !== want) begin
        $error("covered mismatch: expected %0b, got %0b", want, d[0]);
        errors++;
      end
      if (d[OUT_DATA_W-1:1] !== '0) begin
        $error("fill mismatch: expected 0, got %0h", d[OUT_DATA_W-1:1]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_CULL_ENABLE;
  logic                  cfg_wdata = 1'b0;

  coverage_scoreboard sb;
  longint cycle_cnt = 0;
  int src_gap_pct = 0;
  int snk_stall_pct = 0;
  tri_beat_t directed_q[$];

  triangle_pixel_coverage_test_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        sb.note_input(tri_beat_t'(in_tdata));
      end
    end
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic coord_t near(longint base, longint span);
    return clamp_coord(base + longint'($urandom_range(2 * span)) - span);
  endfunction

  function automatic tri_beat_t mk_tri(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint px, longint py);
    tri_beat_t t;
    t.ax = clamp_coord(ax); t.ay = clamp_coord(ay);
    t.bx = clamp_coord(bx); t.by = clamp_coord(by);
    t.cx = clamp_coord(cx); t.cy = clamp_coord(cy);
    t.px = clamp_coord(px); t.py = clamp_coord(py);
    return t;
  endfunction

  function automatic tri_beat_t rand_triangle();
    tri_beat_t t;
    longint ox, oy, span, lo, hi;
    int kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      t = tri_beat_t'({$urandom, $urandom, $urandom, $urandom});
      return t;
    end
    case ($urandom_range(3))
      0: span = 2;
      1: span = 16;
      2: span = 300;
      default: span = 8192;
    endcase
    ox = longint'($signed(16'($urandom)));
    oy = longint'($signed(16'($urandom)));
    t.ax = near(ox, span); t.ay = near(oy, span);
    t.bx = near(ox, span); t.by = near(oy, span);
    t.cx = near(ox, span); t.cy = near(oy, span);
    if (kind < 24) begin
      // zero-area shapes
      case ($urandom_range(2))
        0: begin
          t.bx = t.ax; t.by = t.ay;
        end
        1: begin
          t.cx = clamp_coord(2 * longint'(t.bx) - t.ax);
          t.cy = clamp_coord(2 * longint'(t.by) - t.ay);
        end
        default: begin
          t.bx = t.ax; t.by = t.ay;
          t.cx = t.ax; t.cy = t.ay;
        end
      endcase
    end else if (kind < 44) begin
      // flat and vertical edges
      if ($urandom_range(1)) begin
        t.by = t.ay; t.cx = t.ax;
      end else begin
        t.cy = t.by; t.ax = t.cx;
      end
    end
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(2))
          0: begin t.px = t.ax; t.py = t.ay; end
          1: begin t.px = t.bx; t.py = t.by; end
          default: begin t.px = t.cx; t.py = t.cy; end
        endcase
      end
      1: begin
        case ($urandom_range(2))
          0: begin
            t.px = clamp_coord((longint'(t.ax) + t.bx) / 2);
            t.py = clamp_coord((longint'(t.ay) + t.by) / 2);
          end
          1: begin
            t.px = clamp_coord((longint'(t.bx) + t.cx) / 2);
            t.py = clamp_coord((longint'(t.by) + t.cy) / 2);
          end
          default: begin
            t.px = clamp_coord((longint'(t.cx) + t.ax) / 2);
            t.py = clamp_coord((longint'(t.cy) + t.ay) / 2);
          end
        endcase
      end
      2: begin
        t.px = clamp_coord((longint'(t.ax) + t.bx + t.cx) / 3);
        t.py = clamp_coord((longint'(t.ay) + t.by + t.cy) / 3);
      end
      3, 4: begin
        lo = t.ax; hi = t.ax;
        if (t.bx < lo) lo = t.bx;
        if (t.cx < lo) lo = t.cx;
        if (t.bx > hi) hi = t.bx;
        if (t.cx > hi) hi = t.cx;
        t.px = clamp_coord(lo + longint'($urandom_range(hi - lo)));
        lo = t.ay; hi = t.ay;
        if (t.by < lo) lo = t.by;
        if (t.cy < lo) lo = t.cy;
        if (t.by > hi) hi = t.by;
        if (t.cy > hi) hi = t.cy;
        t.py = clamp_coord(lo + longint'($urandom_range(hi - lo)));
      end
      default: begin
        t.px = near(ox, span);
        t.py = near(oy, span);
      end
    endcase
    return t;
  endfunction

  task automatic drive_triangle(input tri_beat_t t);
    if ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_gap_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic stop_and_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit cull, input bit ccw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CULL_ENABLE;
    cfg_wdata <= cull;
    @(posedge clk);
    cfg_index <= CFG_CCW_FRONT;
    cfg_wdata <= ccw;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(cull, ccw);
  endtask

  initial begin
    bit seg_cull[SEGMENTS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    bit seg_ccw[SEGMENTS]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    sb = new();
    directed_q.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768));
    directed_q.push_back(mk_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed_q.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    directed_q.push_back(mk_tri(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0));
    directed_q.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                                -32768, 32767));
    directed_q.push_back(mk_tri(-32768, -32768, 32767, -32768, 32767, 32767,
                                32767, 32767));
    directed_q.push_back(mk_tri(32767, 32767, -32768, 32767, 32767, -32768,
                                -32768, -32768));
    // right triangle, both windings: inside, each edge, corners, outside
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 16, 16));
    directed_q.push_back(mk_tri(0, 0, 0, 64, 64, 0, 16, 16));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 32, 0));
    directed_q.push_back(mk_tri(0, 0, 0, 64, 64, 0, 32, 0));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 0, 32));
    directed_q.push_back(mk_tri(0, 0, 0, 64, 64, 0, 0, 32));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 32, 32));
    directed_q.push_back(mk_tri(0, 0, 0, 64, 64, 0, 32, 32));
    directed_q.push_back(mk_tri(0, 64, 64, 64, 64, 0, 64, 32));
    directed_q.push_back(mk_tri(0, 64, 64, 0, 64, 64, 32, 64));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 0, 0));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 64, 0));
    directed_q.push_back(mk_tri(0, 0, 64, 0, 0, 64, 100, 100));
    directed_q.push_back(mk_tri(0, 0, 16, 16, 32, 32, 16, 16));
    directed_q.push_back(mk_tri(5, -7, 5, -7, 5, -7, 5, -7));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      src_gap_pct   = (seg < 2) ? 8 : (seg < 4) ? 59 : 0;
      snk_stall_pct = (seg < 2) ? 59 : (seg < 4) ? 8 : 0;
      stop_and_drain();
      write_mode(seg_cull[seg], seg_ccw[seg]);
      if (seg == 0) begin
        foreach (directed_q[i]) drive_triangle(directed_q[i]);
      end
      for (int n = 0; n < RANDOM_PER_SEG; n++) drive_triangle(rand_triangle());
    end
    stop_and_drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: triangle_pixel_coverage_test_top.f
hw/rtl/trc_pkg.sv
hw/rtl/trc_edge.sv
hw/rtl/trc_decide.sv
hw/rtl/triangle_pixel_coverage_test_top.sv
hw/rtl/trc_checker.sv
verif/triangle_pixel_coverage_test_top_test.sv
